### design/moc_pkg.sv
// shared constants, codes and types of the monomial order comparator
package moc_pkg;

    localparam int LANES        = 8;
    localparam int LANE_W       = 8;
    localparam int WORD_W       = LANES * LANE_W;
    localparam int DEG_W        = 11;
    localparam int DEF_NUM_VARS = 8;
    localparam int DEF_EXP_BITS = 8;
    localparam int ORDER_W      = 3;
    localparam int AVARS_W      = 4;
    localparam int APB_DW       = 32;
    localparam int APB_AW       = 3;

    localparam logic [AVARS_W-1:0] ACTIVE_VARS_RST = AVARS_W'(8);

    typedef enum logic [ORDER_W-1:0] {
        ORD_LEX          = 3'd0,
        ORD_REVLEX       = 3'd1,
        ORD_DEGLEX       = 3'd2,
        ORD_REVDEGLEX    = 3'd3,
        ORD_DEGREVLEX    = 3'd4,
        ORD_REVDEGREVLEX = 3'd5
    } t_order_mode;

    typedef enum logic [0:0] {
        REG_ORDER_MODE  = 1'b0,
        REG_ACTIVE_VARS = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic              order_less;
        logic              vectors_equal;
        logic              left_divides_right;
        logic              right_divides_left;
        logic              disjoint_vars;
        logic [WORD_W-1:0] lcm_exps;
        logic [WORD_W-1:0] sum_exps;
        logic              sum_overflow;
        logic [WORD_W-1:0] diff_exps;
        logic              diff_underflow;
        logic [DEG_W-1:0]  lhs_degree;
        logic [DEG_W-1:0]  rhs_degree;
    } t_moc_result;

endpackage

### design/moc_if.sv
// request and result channel interfaces of the monomial order comparator
interface moc_req_if import moc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] lhs_exps;
    logic [WORD_W-1:0] rhs_exps;

    modport source (output valid, lhs_exps, rhs_exps, input ready);
    modport sink   (input valid, lhs_exps, rhs_exps, output ready);
endinterface

interface moc_res_if import moc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              order_less;
    logic              vectors_equal;
    logic              left_divides_right;
    logic              right_divides_left;
    logic              disjoint_vars;
    logic [WORD_W-1:0] lcm_exps;
    logic [WORD_W-1:0] sum_exps;
    logic              sum_overflow;
    logic [WORD_W-1:0] diff_exps;
    logic              diff_underflow;
    logic [DEG_W-1:0]  lhs_degree;
    logic [DEG_W-1:0]  rhs_degree;

    modport source (
        output valid, order_less, vectors_equal, left_divides_right, right_divides_left,
               disjoint_vars, lcm_exps, sum_exps, sum_overflow, diff_exps, diff_underflow,
               lhs_degree, rhs_degree,
        input  ready
    );
    modport sink (
        input  valid, order_less, vectors_equal, left_divides_right, right_divides_left,
               disjoint_vars, lcm_exps, sum_exps, sum_overflow, diff_exps, diff_underflow,
               lhs_degree, rhs_degree,
        output ready
    );
endinterface

### design/monomial_order_compare_unit.sv
// monomial term order comparator: order test, lcm, product, quotient and degrees
// a request passes the input register, then the result register
// throughput: one request per cycle while o_res is ready, set by the register pair
// the logic between them is one lane-parallel pass plus an 8-input degree adder
// reset (synchronous, active low) empties both stages, order_mode to lex, active_vars to 8
module monomial_order_compare_unit
    import moc_pkg::*;
#(
    parameter int NUM_VARS = DEF_NUM_VARS,
    parameter int EXP_BITS = DEF_EXP_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    moc_req_if.sink           i_req,
    moc_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // low EXP_BITS of each 8-bit lane carry the exponent
    localparam logic [LANE_W-1:0] EXP_MASK = LANE_W'((1 << EXP_BITS) - 1);

    // configuration registers
    logic [ORDER_W-1:0] r_order_mode;
    logic [AVARS_W-1:0] r_active_vars;

    // stage 1: captured request
    logic               r_s1_valid;
    logic [WORD_W-1:0]  r_lhs;
    logic [WORD_W-1:0]  r_rhs;

    // stage 2: result register
    logic               r_res_valid;
    t_moc_result        r_res;
    t_moc_result        n_res;

    logic               res_load;
    logic               cfg_write;
    t_cfg_reg           cfg_sel;

    // ---------------------------------------------------------------
    // apb configuration port
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_sel   = t_cfg_reg'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_mode  <= ORD_LEX;
            r_active_vars <= ACTIVE_VARS_RST;
        end else if (cfg_write) begin
            case (cfg_sel)
                REG_ORDER_MODE:  r_order_mode  <= pwdata[ORDER_W-1:0];
                REG_ACTIVE_VARS: r_active_vars <= pwdata[AVARS_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback, unused upper bits read as zero
    always_comb begin
        case (cfg_sel)
            REG_ORDER_MODE:  prdata = APB_DW'(r_order_mode);
            REG_ACTIVE_VARS: prdata = APB_DW'(r_active_vars);
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // handshake: the result register loads when empty or being drained,
    // and stage 1 moves whenever it is empty or can pass its request on
    // ---------------------------------------------------------------
    assign res_load    = !r_res_valid || o_res.ready;
    assign i_req.ready = !r_s1_valid || res_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_s1_valid <= i_req.valid;
            end
            if (res_load) begin
                r_res_valid <= r_s1_valid;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_lhs <= i_req.lhs_exps;
            r_rhs <= i_req.rhs_exps;
        end
        if (res_load && r_s1_valid) begin
            r_res <= n_res;
        end
    end

    // ---------------------------------------------------------------
    // single pass over the lanes. inactive lanes are forced to zero, which
    // makes them neutral for every flag and for the order scans
    // ---------------------------------------------------------------
    always_comb begin
        logic [LANE_W-1:0] x;
        logic [LANE_W-1:0] y;
        logic [LANE_W:0]   s;
        logic [LANE_W-1:0] sat;
        logic [LANES-1:0]  lt;
        logic [LANES-1:0]  gt;
        logic [DEG_W-1:0]  deg_l;
        logic [DEG_W-1:0]  deg_r;
        logic              first_lt;
        logic              first_gt;
        logic              last_lt;
        logic              last_gt;
        logic              graded;
        logic              less;

        n_res = '0;
        n_res.vectors_equal      = 1'b1;
        n_res.left_divides_right = 1'b1;
        n_res.right_divides_left = 1'b1;
        n_res.disjoint_vars      = 1'b1;
        deg_l = '0;
        deg_r = '0;
        lt    = '0;
        gt    = '0;

        for (int i = 0; i < LANES; i++) begin
            x = '0;
            y = '0;
            if (i < NUM_VARS && AVARS_W'(i) < r_active_vars) begin
                x = r_lhs[i*LANE_W +: LANE_W] & EXP_MASK;
                y = r_rhs[i*LANE_W +: LANE_W] & EXP_MASK;
            end
            s = {1'b0, x} + {1'b0, y};
            if (s > {1'b0, EXP_MASK}) begin
                sat = EXP_MASK;
                n_res.sum_overflow = 1'b1;
            end else begin
                sat = s[LANE_W-1:0];
            end
            lt[i] = x < y;
            gt[i] = x > y;
            if (x != y) n_res.vectors_equal = 1'b0;
            if (gt[i]) n_res.left_divides_right = 1'b0;
            if (lt[i]) n_res.right_divides_left = 1'b0;
            if (lt[i]) n_res.diff_underflow = 1'b1;
            if (x != '0 && y != '0) n_res.disjoint_vars = 1'b0;
            n_res.lcm_exps[i*LANE_W +: LANE_W]  = gt[i] ? x : y;
            n_res.sum_exps[i*LANE_W +: LANE_W]  = sat;
            n_res.diff_exps[i*LANE_W +: LANE_W] = gt[i] ? (x - y) : '0;
            deg_l = deg_l + DEG_W'(x);
            deg_r = deg_r + DEG_W'(y);
        end

        // first differing lane from variable 1 upward
        first_lt = 1'b0;
        first_gt = 1'b0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (lt[i] || gt[i]) begin
                first_lt = lt[i];
                first_gt = gt[i];
            end
        end
        // last differing lane
        last_lt = 1'b0;
        last_gt = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            if (lt[i] || gt[i]) begin
                last_lt = lt[i];
                last_gt = gt[i];
            end
        end

        graded = r_order_mode inside {[ORD_DEGLEX:ORD_REVDEGREVLEX]};

        if (graded && deg_l != deg_r) begin
            less = deg_l < deg_r;
        end else begin
            case (r_order_mode)
                ORD_REVLEX, ORD_REVDEGLEX: less = last_lt;
                ORD_DEGREVLEX:             less = last_gt;
                ORD_REVDEGREVLEX:          less = first_gt;
                default:                   less = first_lt; // lex, deglex, unused codes
            endcase
        end

        n_res.order_less = less;
        n_res.lhs_degree = deg_l;
        n_res.rhs_degree = deg_r;
    end

    // ---------------------------------------------------------------
    // result channel
    // ---------------------------------------------------------------
    assign o_res.valid              = r_res_valid;
    assign o_res.order_less         = r_res.order_less;
    assign o_res.vectors_equal      = r_res.vectors_equal;
    assign o_res.left_divides_right = r_res.left_divides_right;
    assign o_res.right_divides_left = r_res.right_divides_left;
    assign o_res.disjoint_vars      = r_res.disjoint_vars;
    assign o_res.lcm_exps           = r_res.lcm_exps;
    assign o_res.sum_exps           = r_res.sum_exps;
    assign o_res.sum_overflow       = r_res.sum_overflow;
    assign o_res.diff_exps          = r_res.diff_exps;
    assign o_res.diff_underflow     = r_res.diff_underflow;
    assign o_res.lhs_degree         = r_res.lhs_degree;
    assign o_res.rhs_degree         = r_res.rhs_degree;

`ifndef SYNTHESIS
    // an accepted request always lands in stage 1
    a_req_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_s1_valid)
        else $error("accepted request not held in stage 1");

    // a request leaving stage 1 always becomes a visible result
    a_res_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && res_load) |=> r_res_valid)
        else $error("request lost between stage 1 and result register");

    // equal vectors divide each other, are never less and have equal degree
    a_equal_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.vectors_equal) |->
            (r_res.left_divides_right && r_res.right_divides_left &&
             !r_res.order_less && r_res.lhs_degree == r_res.rhs_degree))
        else $error("equal vectors give inconsistent result");

    // mutual divisibility means equality
    a_divides_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.left_divides_right && r_res.right_divides_left) |->
            r_res.vectors_equal)
        else $error("mutual divisibility without equality");
`endif

endmodule

### verif/monomial_order_compare_unit_tb.sv
// self-checking testbench of the monomial order comparator: request driver, result monitor, apb setup
module monomial_order_compare_unit_tb;
    import moc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NUM_VARS       = DEF_NUM_VARS;
    localparam int          EXP_BITS       = DEF_EXP_BITS;
    localparam int unsigned EXP_MAX        = (1 << EXP_BITS) - 1;
    localparam int          PHASES         = 15;
    localparam int          PHASE_REQUESTS = 26;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 4;

    // order codes the package leaves unnamed, both must act as lex
    localparam logic [ORDER_W-1:0] ORD_SPARE_6 = 3'd6;
    localparam logic [ORDER_W-1:0] ORD_SPARE_7 = 3'd7;

    typedef struct {
        logic [WORD_W-1:0] lhs;
        logic [WORD_W-1:0] rhs;
    } t_monomial_pair;

    // shapes of random request content
    typedef enum int unsigned {
        SHAPE_RANDOM,
        SHAPE_EQUAL,
        SHAPE_ONE_LANE,
        SHAPE_SWAP,
        SHAPE_SMALL,
        SHAPE_LARGE,
        SHAPE_DIVIDES,
        SHAPE_SPARSE
    } t_pair_shape;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    moc_req_if req_if ();
    moc_res_if res_if ();

    // pairs waiting for the driver, and order results waiting for the monitor
    t_monomial_pair pending_pairs[$];
    t_moc_result    expected_orders[$];

    // shadow copy of the configuration registers
    logic [ORDER_W-1:0] cfg_order;
    logic [AVARS_W-1:0] cfg_vars;

    int  queued_cnt;
    int  checked_cnt;
    int  error_cnt;
    int  stall_cycles;
    bit  no_gaps;

    monomial_order_compare_unit #(
        .NUM_VARS (NUM_VARS),
        .EXP_BITS (EXP_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // order comparison, lcm, product, quotient and degrees of one pair
    function automatic t_moc_result order_compare(
        input logic [WORD_W-1:0]  lhs,
        input logic [WORD_W-1:0]  rhs,
        input logic [ORDER_W-1:0] mode,
        input logic [AVARS_W-1:0] avars
    );
        t_moc_result r;
        int unsigned x [LANES];
        int unsigned y [LANES];
        int unsigned n, s, deg_l, deg_r, idx;
        bit          graded, downward, larger_wins, decided;
        r = '0;
        r.vectors_equal      = 1'b1;
        r.left_divides_right = 1'b1;
        r.right_divides_left = 1'b1;
        r.disjoint_vars      = 1'b1;
        // more variables than lanes saturates, zero leaves every lane out
        n = (avars > NUM_VARS) ? NUM_VARS : avars;
        deg_l = 0;
        deg_r = 0;
        for (int i = 0; i < LANES; i++) begin
            x[i] = 0;
            y[i] = 0;
        end
        for (int i = 0; i < n; i++) begin
            x[i] = lhs[i*LANE_W +: LANE_W] & EXP_MAX;
            y[i] = rhs[i*LANE_W +: LANE_W] & EXP_MAX;
            s = x[i] + y[i];
            if (x[i] != y[i]) r.vectors_equal = 1'b0;
            if (x[i] > y[i]) r.left_divides_right = 1'b0;
            if (y[i] > x[i]) r.right_divides_left = 1'b0;
            if (x[i] > 0 && y[i] > 0) r.disjoint_vars = 1'b0;
            if (s > EXP_MAX) begin
                r.sum_overflow = 1'b1;
                s = EXP_MAX;
            end
            if (x[i] < y[i]) r.diff_underflow = 1'b1;
            r.lcm_exps[i*LANE_W +: LANE_W]  = LANE_W'((x[i] > y[i]) ? x[i] : y[i]);
            r.sum_exps[i*LANE_W +: LANE_W]  = LANE_W'(s);
            r.diff_exps[i*LANE_W +: LANE_W] = LANE_W'((x[i] > y[i]) ? x[i] - y[i] : 0);
            deg_l += x[i];
            deg_r += y[i];
        end
        r.lhs_degree = DEG_W'(deg_l);
        r.rhs_degree = DEG_W'(deg_r);

        // graded orders settle on degree first, ties fall to the lane scan
        graded = (mode == ORD_DEGLEX) || (mode == ORD_REVDEGLEX) ||
                 (mode == ORD_DEGREVLEX) || (mode == ORD_REVDEGREVLEX);
        if (graded && deg_l != deg_r) begin
            r.order_less = (deg_l < deg_r);
        end else begin
            downward    = (mode == ORD_REVLEX) || (mode == ORD_REVDEGLEX) ||
                          (mode == ORD_DEGREVLEX);
            larger_wins = (mode == ORD_DEGREVLEX) || (mode == ORD_REVDEGREVLEX);
            decided     = 1'b0;
            for (int k = 0; k < n; k++) begin
                idx = downward ? (n - 1 - k) : k;
                if (!decided && x[idx] != y[idx]) begin
                    decided      = 1'b1;
                    r.order_less = larger_wins ? (x[idx] > y[idx]) : (x[idx] < y[idx]);
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("mismatch at result %0d, %s: got %h, want %h", checked_cnt, what, got, want);
        error_cnt++;
    endtask

    task automatic check_result(input t_moc_result got, input t_moc_result want);
        if (got.order_less !== want.order_less)
            report_mismatch("order_less", WORD_W'(got.order_less), WORD_W'(want.order_less));
        if (got.vectors_equal !== want.vectors_equal)
            report_mismatch("vectors_equal", WORD_W'(got.vectors_equal),
                            WORD_W'(want.vectors_equal));
        if (got.left_divides_right !== want.left_divides_right)
            report_mismatch("left_divides_right", WORD_W'(got.left_divides_right),
                            WORD_W'(want.left_divides_right));
        if (got.right_divides_left !== want.right_divides_left)
            report_mismatch("right_divides_left", WORD_W'(got.right_divides_left),
                            WORD_W'(want.right_divides_left));
        if (got.disjoint_vars !== want.disjoint_vars)
            report_mismatch("disjoint_vars", WORD_W'(got.disjoint_vars),
                            WORD_W'(want.disjoint_vars));
        if (got.lcm_exps !== want.lcm_exps)
            report_mismatch("lcm_exps", got.lcm_exps, want.lcm_exps);
        if (got.sum_exps !== want.sum_exps)
            report_mismatch("sum_exps", got.sum_exps, want.sum_exps);
        if (got.sum_overflow !== want.sum_overflow)
            report_mismatch("sum_overflow", WORD_W'(got.sum_overflow),
                            WORD_W'(want.sum_overflow));
        if (got.diff_exps !== want.diff_exps)
            report_mismatch("diff_exps", got.diff_exps, want.diff_exps);
        if (got.diff_underflow !== want.diff_underflow)
            report_mismatch("diff_underflow", WORD_W'(got.diff_underflow),
                            WORD_W'(want.diff_underflow));
        if (got.lhs_degree !== want.lhs_degree)
            report_mismatch("lhs_degree", WORD_W'(got.lhs_degree), WORD_W'(want.lhs_degree));
        if (got.rhs_degree !== want.rhs_degree)
            report_mismatch("rhs_degree", WORD_W'(got.rhs_degree), WORD_W'(want.rhs_degree));
    endtask

    // apb write: setup cycle, access cycle, register taken when pready is high
    task automatic apb_write(input t_cfg_reg idx, input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * idx);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // both registers, with random junk above each field
    task automatic configure(input logic [ORDER_W-1:0] mode, input logic [AVARS_W-1:0] avars);
        logic [APB_DW-1:0] word;
        word = $urandom;
        word[ORDER_W-1:0] = mode;
        apb_write(REG_ORDER_MODE, word);
        word = $urandom;
        word[AVARS_W-1:0] = avars;
        apb_write(REG_ACTIVE_VARS, word);
        cfg_order = mode;
        cfg_vars  = avars;
    endtask

    task automatic queue_pair(input logic [WORD_W-1:0] lhs, input logic [WORD_W-1:0] rhs);
        t_monomial_pair p;
        p.lhs = lhs;
        p.rhs = rhs;
        pending_pairs.push_back(p);
        queued_cnt++;
    endtask

    // random pair, mostly shaped so that lane scans and degree ties go deep
    task automatic queue_random_pair();
        logic [WORD_W-1:0] lhs, rhs;
        logic [LANE_W-1:0] t;
        int unsigned       pick, j, k;
        t_pair_shape       shape;
        pick  = $urandom_range(0, SHAPE_SPARSE + 2);
        shape = (pick > SHAPE_SPARSE) ? SHAPE_RANDOM : t_pair_shape'(pick);
        lhs   = {$urandom, $urandom};
        rhs   = {$urandom, $urandom};
        j     = $urandom_range(0, LANES - 1);
        k     = $urandom_range(0, LANES - 1);
        case (shape)
            SHAPE_EQUAL: begin
                rhs = lhs;
            end
            SHAPE_ONE_LANE: begin
                rhs = lhs;
                rhs[j*LANE_W +: LANE_W] = LANE_W'($urandom);
            end
            SHAPE_SWAP: begin
                // two lanes swapped, same degree if both are active; the vector may also stay the same
                rhs = lhs;
                t   = rhs[j*LANE_W +: LANE_W];
                rhs[j*LANE_W +: LANE_W] = rhs[k*LANE_W +: LANE_W];
                rhs[k*LANE_W +: LANE_W] = t;
            end
            SHAPE_SMALL: begin
                for (int i = 0; i < LANES; i++) begin
                    lhs[i*LANE_W +: LANE_W] = LANE_W'($urandom_range(0, 3));
                    rhs[i*LANE_W +: LANE_W] = LANE_W'($urandom_range(0, 3));
                end
            end
            SHAPE_LARGE: begin
                lhs |= {LANES{8'h80}};
                rhs |= {LANES{8'h80}};
            end
            SHAPE_DIVIDES: begin
                for (int i = 0; i < LANES; i++) begin
                    rhs[i*LANE_W +: LANE_W] = LANE_W'(lhs[i*LANE_W +: LANE_W] +
                        $urandom_range(0, EXP_MAX - lhs[i*LANE_W +: LANE_W]));
                end
            end
            SHAPE_SPARSE: begin
                for (int i = 0; i < LANES; i++) begin
                    if ($urandom_range(0, 1)) lhs[i*LANE_W +: LANE_W] = '0;
                    if ($urandom_range(0, 1)) rhs[i*LANE_W +: LANE_W] = '0;
                end
            end
            default: ;
        endcase
        // keep the left side dividing the right for that shape, swap the rest at random
        if (shape != SHAPE_DIVIDES && $urandom_range(0, 1))
            queue_pair(rhs, lhs);
        else
            queue_pair(lhs, rhs);
    endtask

    // driver: present the next pair, predict at the accepting edge
    always @(posedge i_clk) begin : pair_driver
        t_monomial_pair p;
        if (!i_rst_n) begin
            req_if.valid    <= 1'b0;
            req_if.lhs_exps <= '0;
            req_if.rhs_exps <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_orders.push_back(order_compare(req_if.lhs_exps, req_if.rhs_exps,
                                                        cfg_order, cfg_vars));
            end
            if (req_if.valid && !req_if.ready) begin
                // hold the request until it is taken
            end else if (pending_pairs.size() > 0 &&
                         (no_gaps || $urandom_range(0, 99) >= 17)) begin
                p = pending_pairs.pop_front();
                req_if.valid    <= 1'b1;
                req_if.lhs_exps <= p.lhs;
                req_if.rhs_exps <= p.rhs;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // monitor: compare each taken result with the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_moc_result got;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got = '{res_if.order_less, res_if.vectors_equal, res_if.left_divides_right,
                        res_if.right_divides_left, res_if.disjoint_vars, res_if.lcm_exps,
                        res_if.sum_exps, res_if.sum_overflow, res_if.diff_exps,
                        res_if.diff_underflow, res_if.lhs_degree, res_if.rhs_degree};
                if (expected_orders.size() == 0)
                    report_mismatch("result with no request", got.lcm_exps, '0);
                else
                    check_result(got, expected_orders.pop_front());
                checked_cnt++;
            end
            res_if.ready <= no_gaps || ($urandom_range(0, 99) >= 17);
        end
    end

    // watchdog on cycles with no handshake and no register access
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
            psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // wait until every queued pair has come back, then let the pipe settle
    task automatic drain();
        while (checked_cnt < queued_cnt) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [ORDER_W-1:0] plan_order [PHASES];
        logic [AVARS_W-1:0] plan_vars  [PHASES];
        // every order, the spare codes, no variables, one variable, too many variables
        plan_order = '{ORD_REVLEX, ORD_DEGLEX, ORD_REVDEGLEX, ORD_DEGREVLEX, ORD_REVDEGREVLEX,
                       ORD_SPARE_6, ORD_SPARE_7, ORD_LEX, ORD_DEGREVLEX, ORD_DEGLEX,
                       ORD_REVDEGREVLEX, ORD_REVDEGLEX, ORD_REVLEX, ORD_LEX, ORD_LEX};
        plan_vars  = '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd1, 4'd0, 4'd15,
                       4'd9, 4'd3, 4'd5, 4'd8, 4'd8};
        queued_cnt   = 0;
        checked_cnt  = 0;
        error_cnt    = 0;
        no_gaps      = 1'b0;
        cfg_order    = ORD_LEX;
        cfg_vars     = ACTIVE_VARS_RST;
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pairs under the reset setting: lex over all eight variables
        queue_pair(64'h0, 64'h0);
        queue_pair({LANES{8'hff}}, {LANES{8'hff}});
        queue_pair({LANES{8'hff}}, 64'h0);
        queue_pair(64'h0, {LANES{8'hff}});
        queue_pair(64'h0000_0000_0000_0001, 64'h0100_0000_0000_0000);
        queue_pair(64'h0100_0000_0000_0000, 64'h0000_0000_0000_0001);
        queue_pair(64'h0102_0304_0506_0708, 64'h0807_0605_0403_0201);
        queue_pair(64'h2233_4455_6677_8899, 64'h2333_4455_6677_8899);
        queue_pair({LANES{8'h80}}, {LANES{8'h80}});
        queue_pair({LANES{8'h7f}}, {LANES{8'h80}});
        queue_pair({LANES{8'haa}}, {LANES{8'h55}});
        queue_pair(64'h0003_0000_0200_0001, 64'h0104_0000_0300_0001);
        queue_pair(64'hff00_ff00_ff00_ff00, 64'h00ff_00ff_00ff_00ff);
        queue_pair(64'h0101_0101_0101_0101, 64'h0000_0000_0000_0008);
        drain();

        for (int ph = 0; ph < PHASES + 2; ph++) begin
            if (ph < PHASES)
                configure(plan_order[ph], plan_vars[ph]);
            else
                configure(ORDER_W'($urandom_range(0, 7)), AVARS_W'($urandom_range(0, 15)));
            // a long stretch with both sides always ready
            no_gaps = (ph == 3) || (ph == 4);
            for (int i = 0; i < PHASE_REQUESTS - (ph >= PHASES ? 4 : 0); i++)
                queue_random_pair();
            drain();
        end

        if (expected_orders.size() != 0)
            report_mismatch("predictions left over", WORD_W'(expected_orders.size()), '0);
        if (error_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
